>>> hdl/rbfi_pkg.sv
// Shared types, codes and defaults for the ring buffer with front insert.
`default_nettype none

package rbfi_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int ACTION_W       = 2;
    localparam int STATUS_W       = 2;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_FLUSH      = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 2'd0,
        STS_NO_STORAGE = 2'd1,
        STS_OVERFLOW   = 2'd2,
        STS_UNDERFLOW  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic    push_back;
        logic    push_front;
        logic    pop;
        logic    flush;
        logic    load_out;
        logic    from_ram;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic cap_zero;
        logic empty;
        logic full;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/rbfi_ram.sv
// Generic single-write, registered-read RAM.
`default_nettype none

module rbfi_ram #(
    parameter int WIDTH = rbfi_pkg::WORD_WIDTH_DEF,
    parameter int DEPTH = rbfi_pkg::DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/rbfi_ctrl.sv
// Request controller: decodes each beat and sequences the datapath.
`default_nettype none

module rbfi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire rbfi_pkg::t_action i_action,
    input  wire logic             i_out_ready,
    input  wire rbfi_pkg::t_sts   i_sts,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output rbfi_pkg::t_cmd        o_cmd
);

    rbfi_pkg::t_state r_state;
    rbfi_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;
    logic             w_pop_ok;

    assign o_in_ready  = (r_state == rbfi_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_pop_ok    = (i_action == rbfi_pkg::ACT_POP_FRONT) && !i_sts.cap_zero
                         && !i_sts.empty;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbfi_pkg::ST_IDLE: begin
                if (w_accept && w_pop_ok) begin
                    n_state = rbfi_pkg::ST_READ;
                end
            end
            rbfi_pkg::ST_READ: begin
                n_state = rbfi_pkg::ST_IDLE;
            end
            default: begin
                n_state = rbfi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = rbfi_pkg::STS_OK;
        case (r_state)
            rbfi_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == rbfi_pkg::ACT_FLUSH) begin
                        o_cmd.flush    = 1'b1;
                        o_cmd.load_out = 1'b1;
                    end else if (i_sts.cap_zero) begin
                        o_cmd.status   = rbfi_pkg::STS_NO_STORAGE;
                        o_cmd.load_out = 1'b1;
                    end else if (i_action == rbfi_pkg::ACT_POP_FRONT) begin
                        if (i_sts.empty) begin
                            o_cmd.status   = rbfi_pkg::STS_UNDERFLOW;
                            o_cmd.load_out = 1'b1;
                        end else begin
                            o_cmd.pop = 1'b1;
                        end
                    end else if (i_sts.full) begin
                        o_cmd.status   = rbfi_pkg::STS_OVERFLOW;
                        o_cmd.load_out = 1'b1;
                    end else begin
                        o_cmd.push_back  = (i_action == rbfi_pkg::ACT_PUSH_BACK);
                        o_cmd.push_front = (i_action == rbfi_pkg::ACT_PUSH_FRONT);
                        o_cmd.load_out   = 1'b1;
                    end
                end
            end
            rbfi_pkg::ST_READ: begin
                o_cmd.load_out = 1'b1;
                o_cmd.from_ram = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbfi_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rbfi_dp.sv
// Queue datapath: capacity, indices, count, entry RAM and result register.
`default_nettype none

module rbfi_dp #(
    parameter int DEPTH      = rbfi_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = rbfi_pkg::WORD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rbfi_pkg::APB_DATA_W-1:0]   i_cfg_data,
    input  wire logic [rbfi_pkg::DATA_W-1:0]       i_data,
    input  wire rbfi_pkg::t_cmd                    i_cmd,
    output rbfi_pkg::t_sts                         o_sts,
    output logic      [$clog2(DEPTH+1)-1:0]        o_cap,
    output rbfi_pkg::t_status                      o_status,
    output logic      [rbfi_pkg::DATA_W-1:0]       o_read_data,
    output logic      [$clog2(DEPTH+1)-1:0]        o_count,
    output logic                                   o_is_empty,
    output logic                                   o_is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [CW-1:0] r_cap;
    logic [CW-1:0] n_cap;
    logic [AW-1:0] r_wr_idx;
    logic [AW-1:0] n_wr_idx;
    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] n_rd_idx;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_cfg_cap;
    logic [CW-1:0] w_cap_m1;

    logic                    w_ram_we;
    logic [AW-1:0]           w_ram_waddr;
    logic [WORD_WIDTH-1:0]   w_ram_rdata;

    rbfi_pkg::t_status            r_status;
    logic [rbfi_pkg::DATA_W-1:0]  r_read_data;
    logic [CW-1:0]                r_out_count;
    logic                         r_is_empty;
    logic                         r_is_full;

    assign w_cfg_cap = (i_cfg_data[CW-1:0] > CW'(DEPTH)) ? CW'(DEPTH) : i_cfg_data[CW-1:0];
    assign w_cap_m1  = r_cap - CW'(1);

    assign o_sts.cap_zero = (r_cap == '0);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count >= r_cap);
    assign o_cap          = r_cap;

    always_comb begin
        n_cap    = r_cap;
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (i_cfg_we) begin
            n_cap    = w_cfg_cap;
            n_wr_idx = '0;
            n_rd_idx = '0;
            n_count  = '0;
        end else if (i_cmd.flush) begin
            n_wr_idx = '0;
            n_rd_idx = '0;
            n_count  = '0;
        end else if (i_cmd.push_back) begin
            n_wr_idx = (CW'(r_wr_idx) == w_cap_m1) ? '0 : r_wr_idx + AW'(1);
            n_count  = r_count + CW'(1);
        end else if (i_cmd.push_front) begin
            n_rd_idx = (r_rd_idx == '0) ? w_cap_m1[AW-1:0] : r_rd_idx - AW'(1);
            n_count  = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_rd_idx = (CW'(r_rd_idx) == w_cap_m1) ? '0 : r_rd_idx + AW'(1);
            n_count  = r_count - CW'(1);
        end
    end

    assign w_ram_we    = i_cmd.push_back || i_cmd.push_front;
    assign w_ram_waddr = i_cmd.push_front ? n_rd_idx : r_wr_idx;

    rbfi_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (WORD_WIDTH'(i_data)),
        .i_raddr (r_rd_idx),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CW'(DEPTH);
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_cap    <= n_cap;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status    <= i_cmd.status;
            r_read_data <= i_cmd.from_ram ? rbfi_pkg::DATA_W'(w_ram_rdata) : '0;
            r_out_count <= n_count;
            r_is_empty  <= (n_count == '0);
            r_is_full   <= (n_count == r_cap);
        end
    end

    assign o_status    = r_status;
    assign o_read_data = r_read_data;
    assign o_count     = r_out_count;
    assign o_is_empty  = r_is_empty;
    assign o_is_full   = r_is_full;

endmodule

`default_nettype wire

>>> hdl/ring_buffer_with_front_insert.sv
// Top level of the ring buffer with front insert.
// Push, flush and rejected requests load the result register at the input beat; a
// successful pop first reads the registered entry RAM, then loads the result register.
// Throughput: one beat per cycle, held back by output stalls and a pop's RAM read.
// Reset (synchronous, active low) empties the queue and sets capacity to DEPTH;
// the entry RAM is not cleared.
`default_nettype none

module ring_buffer_with_front_insert #(
    parameter int DEPTH      = rbfi_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = rbfi_pkg::WORD_WIDTH_DEF,
    parameter int OUT_W      = ((rbfi_pkg::DATA_W + $clog2(DEPTH+1) + 2 + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // data[31:0]
    input  wire logic [rbfi_pkg::DATA_W-1:0]       s_axis_tdata,
    // action[1:0]
    input  wire logic [rbfi_pkg::ACTION_W-1:0]     s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // read_data[31:0], count, is_empty, is_full, zero pad
    output logic      [OUT_W-1:0]                  m_axis_tdata,
    // status[1:0]
    output logic      [rbfi_pkg::STATUS_W-1:0]     m_axis_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rbfi_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rbfi_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rbfi_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int CW = $clog2(DEPTH+1);

    rbfi_pkg::t_cmd    w_cmd;
    rbfi_pkg::t_sts    w_sts;
    rbfi_pkg::t_status w_status;
    logic              w_cfg_we;
    logic [CW-1:0]     w_cap;
    logic [rbfi_pkg::DATA_W-1:0] w_read_data;
    logic [CW-1:0]     w_count;
    logic              w_is_empty;
    logic              w_is_full;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? rbfi_pkg::APB_DATA_W'(w_cap) : '0;

    rbfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_action    (rbfi_pkg::t_action'(s_axis_tuser)),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    rbfi_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_data  (pwdata),
        .i_data      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_cap       (w_cap),
        .o_status    (w_status),
        .o_read_data (w_read_data),
        .o_count     (w_count),
        .o_is_empty  (w_is_empty),
        .o_is_full   (w_is_full)
    );

    assign m_axis_tuser = w_status;
    assign m_axis_tdata = OUT_W'({w_is_full, w_is_empty, w_count, w_read_data});

endmodule

`default_nettype wire

>>> hdl/rbfi_chk.sv
// Port-level checker for the ring buffer with front insert, bound to the top level.
`default_nettype none

module rbfi_chk #(
    parameter int DEPTH = rbfi_pkg::DEPTH_DEF,
    parameter int OUT_W = 40
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [OUT_W-1:0]              m_axis_tdata,
    input wire logic [rbfi_pkg::STATUS_W-1:0] m_axis_tuser
);

    localparam int CW = $clog2(DEPTH+1);
    localparam int DW = rbfi_pkg::DATA_W;

    logic [DW-1:0] w_rdata;
    logic [CW-1:0] w_count;
    logic          w_empty;
    logic          w_full;

    assign w_rdata = m_axis_tdata[DW-1:0];
    assign w_count = m_axis_tdata[DW+CW-1:DW];
    assign w_empty = m_axis_tdata[DW+CW];
    assign w_full  = m_axis_tdata[DW+CW+1];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_empty == (w_count == '0)))
        else $error("empty flag disagrees with count");

    a_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != rbfi_pkg::STS_OK) |-> (w_rdata == '0))
        else $error("failed request returned nonzero data");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == rbfi_pkg::STS_OVERFLOW) |-> w_full && !w_empty)
        else $error("overflow reported on a queue that is not full");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count <= CW'(DEPTH)))
        else $error("count exceeds depth");

endmodule

bind ring_buffer_with_front_insert rbfi_chk #(
    .DEPTH (DEPTH),
    .OUT_W (OUT_W)
) u_rbfi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
